// ===== rtl/core/mpad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpad_pkg
// Shared constants, command and register codes, and the types that pass
// between the dimmer controller and the channel cells.
// ----------------------------------------------------------------------------
package mpad_pkg;

    // Sizing
    localparam int CHANNELS  = 8;
    localparam int TIME_BITS = 20;
    localparam int DELAY_W   = 16;
    localparam int GATES_W   = 8;
    localparam int SCAN_CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Timing constants in microseconds, and the top brightness level
    localparam int OFF_EXTRA  = 2000;
    localparam int FAR_DELAY  = 8500;
    localparam int GROUP_TOL  = 10;
    localparam int TOP_LEVEL  = 9;
    localparam int NONE_EXTRA = 5000;
    localparam int MIN_GAP    = 10;

    // Divide by nine: floor(n * RECIP9 / 2^RECIP_SHIFT) is exact for n < 2^17
    localparam int RECIP9      = 116509;
    localparam int RECIP_SHIFT = 20;

    // Configuration reset values
    localparam int HALF_RST  = 10000;
    localparam int MIN_RST   = 500;
    localparam int DEB_RST   = 3000;
    localparam int LOST_RST  = 100000;
    localparam int PULSE_RST = 10;
    localparam int DELAY_RST = HALF_RST + OFF_EXTRA;

    // Item commands
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_SET_ONE = 2'd1;
    localparam logic [1:0] CMD_SET_ALL = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEB   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE = 3'd4;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic               found;
        logic [DELAY_W-1:0] best;
    } t_scan;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic [14:0]        half;
        logic [DELAY_W-1:0] wr_data;
        logic               clr_marks;
        logic               grp_en;
        logic [DELAY_W-1:0] target;
    } t_cell_ctl;

endpackage

// ===== rtl/core/mpad_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpad_cell
// One dimmer channel: holds its firing delay and fired mark, folds itself
// into the running minimum passed along the chain, and flags membership of
// the group being fired.
// ----------------------------------------------------------------------------
module mpad_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpad_pkg::t_cell_ctl i_ctl,
    input  logic              i_wr,
    input  mpad_pkg::t_scan   i_scan,
    output mpad_pkg::t_scan   o_scan,
    output logic              o_grp
);
    import mpad_pkg::*;

    logic [DELAY_W-1:0] r_delay;
    logic               r_mark;
    t_scan              r_scan;
    logic               pending;
    logic               take;

    // Pending: not yet fired and early enough to fire in this half cycle
    assign pending = !r_mark && (r_delay < {1'b0, i_ctl.half});
    assign take    = pending && (r_delay < i_scan.best);
    assign o_grp   = pending &&
                     ({1'b0, r_delay} <= ({1'b0, i_ctl.target} + 17'(GROUP_TOL)));

    // Hold delay and fired mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_W'(DELAY_RST);
            r_mark  <= 1'b0;
        end else begin
            if (i_wr) begin
                r_delay <= i_ctl.wr_data;
            end
            if (i_ctl.clr_marks) begin
                r_mark <= 1'b0;
            end else if (i_ctl.grp_en && o_grp) begin
                r_mark <= 1'b1;
            end
        end
    end

    // Advance the running minimum to the next cell
    always_ff @(posedge i_clk) begin
        r_scan.found <= i_scan.found | take;
        r_scan.best  <= take ? r_delay : i_scan.best;
    end

    assign o_scan = r_scan;

endmodule

// ===== rtl/core/mpad_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpad_ctrl
// Dimmer sequencer: configuration registers, tick timing, firing countdown,
// gate pulse, watchdog, brightness-to-delay mapping and the result register.
// ----------------------------------------------------------------------------
module mpad_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mpad_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mpad_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_cmd,
    input  logic [2:0]                             i_channel,
    input  logic [3:0]                             i_brightness,
    input  logic                                   i_zc_edge,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [mpad_pkg::GATES_W-1:0]           o_gates,
    output logic                                   o_zc_healthy,
    output logic                                   o_emergency,
    output logic                                   o_timer_armed,
    output logic [15:0]                            o_last_fire_delay,
    output mpad_pkg::t_cell_ctl                    o_ctl,
    output logic [mpad_pkg::CHANNELS-1:0]          o_wr,
    output mpad_pkg::t_scan                        o_seed,
    input  mpad_pkg::t_scan                        i_scan_end,
    input  logic [mpad_pkg::CHANNELS-1:0]          i_grp
);
    import mpad_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TICK   = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;
    localparam logic [3:0] S_FIRE   = 4'd3;
    localparam logic [3:0] S_SCHED  = 4'd4;
    localparam logic [3:0] S_EDGE   = 4'd5;
    localparam logic [3:0] S_WDOG   = 4'd6;
    localparam logic [3:0] S_LV_MUL = 4'd7;
    localparam logic [3:0] S_LV_DIV = 4'd8;
    localparam logic [3:0] S_LV_WR  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Configuration
    logic [14:0] r_half;
    logic [13:0] r_min;
    logic [15:0] r_deb;
    logic [19:0] r_lost;
    logic [7:0]  r_pulse;

    // Sequencer
    logic [3:0]         r_state, n_state;
    logic               r_after_fire, n_after_fire;
    logic               r_sched_fire, n_sched_fire;
    logic [SCAN_CW-1:0] r_wait, n_wait;

    // Captured item
    logic [1:0] r_cmd;
    logic [2:0] r_ch;
    logic [3:0] r_level;
    logic       r_edge;

    // Dimmer state
    logic [TIME_BITS-1:0] r_since, n_since;
    logic [15:0]          r_fref, n_fref;
    logic [15:0]          r_countdown, n_countdown;
    logic                 r_armed, n_armed;
    logic                 r_healthy, n_healthy;
    logic                 r_shutoff, n_shutoff;
    logic [7:0]           r_pulse_left, n_pulse_left;
    logic [CHANNELS-1:0]  r_gate, n_gate;

    // Level mapping pipeline
    logic signed [17:0] r_prod;
    logic [13:0]        r_quot;
    logic               r_neg;
    logic signed [4:0]  lv_x;
    logic signed [14:0] lv_diff;
    logic signed [19:0] lv_prod;
    logic [16:0]        lv_abs;
    logic [33:0]        lv_mul;
    logic [16:0]        lv_sum;
    logic [15:0]        lv_delay;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic [GATES_W-1:0] r_o_gates;
    logic               r_o_healthy;
    logic               r_o_emerg;
    logic               r_o_armed;
    logic [15:0]        r_o_fref;

    logic        accept;
    logic        out_load;
    logic [15:0] cd_step;
    logic [15:0] gap;
    logic        zc_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= 15'(HALF_RST);
            r_min   <= 14'(MIN_RST);
            r_deb   <= 16'(DEB_RST);
            r_lost  <= 20'(LOST_RST);
            r_pulse <= 8'(PULSE_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HALF:  r_half  <= i_cfg_data[14:0];
                CFG_MIN:   r_min   <= i_cfg_data[13:0];
                CFG_DEB:   r_deb   <= i_cfg_data[15:0];
                CFG_LOST:  r_lost  <= i_cfg_data[19:0];
                CFG_PULSE: r_pulse <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_ch    <= i_channel;
            r_level <= (i_brightness > 4'(TOP_LEVEL)) ? 4'(TOP_LEVEL) : i_brightness;
            r_edge  <= i_zc_edge;
        end
    end

    // Level 1-8 delay: (9 - level) * (8500 - min) / 9 + min, rounded toward zero
    assign lv_x    = $signed({1'b0, 4'(TOP_LEVEL) - r_level});
    assign lv_diff = $signed(15'(FAR_DELAY)) - $signed({1'b0, r_min});
    assign lv_prod = lv_x * lv_diff;
    assign lv_abs  = r_prod[17] ? 17'(-r_prod) : 17'(r_prod);
    assign lv_mul  = 34'(lv_abs) * 34'(RECIP9);
    assign lv_sum  = r_neg ? ({3'b000, r_min} - {3'b000, r_quot})
                           : ({3'b000, r_min} + {3'b000, r_quot});

    always_comb begin
        if (r_level == 4'd0) begin
            lv_delay = 16'({1'b0, r_half} + 16'(OFF_EXTRA));
        end else if (r_level == 4'(TOP_LEVEL)) begin
            lv_delay = {2'b00, r_min};
        end else begin
            lv_delay = lv_sum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LV_MUL) begin
            r_prod <= lv_prod[17:0];
        end
        if (r_state == S_LV_DIV) begin
            r_quot <= lv_mul[RECIP_SHIFT+13:RECIP_SHIFT];
            r_neg  <= r_prod[17];
        end
    end

    // Countdown step, gap to the next group, debounced zero cross
    assign cd_step = (r_countdown != 16'd0) ? (r_countdown - 16'd1) : 16'd0;
    assign zc_take = r_edge && (r_since >= TIME_BITS'(r_deb));

    always_comb begin
        if (i_scan_end.best > r_fref) begin
            gap = i_scan_end.best - r_fref;
        end else begin
            gap = 16'd1;
        end
        if (gap < 16'(MIN_GAP)) begin
            gap = 16'(MIN_GAP);
        end
    end

    // Chain seed and broadcast control
    assign o_seed.found = 1'b0;
    assign o_seed.best  = 16'({1'b0, r_half} + 16'(NONE_EXTRA));

    always_comb begin
        o_ctl.half      = r_half;
        o_ctl.wr_data   = lv_delay;
        o_ctl.clr_marks = (r_state == S_EDGE) && zc_take;
        o_ctl.grp_en    = (r_state == S_FIRE) && i_scan_end.found;
        o_ctl.target    = i_scan_end.best;
        for (int k = 0; k < CHANNELS; k++) begin
            o_wr[k] = (r_state == S_LV_WR) &&
                      ((r_cmd == CMD_SET_ALL) ||
                       ((r_cmd == CMD_SET_ONE) && (int'(r_ch) == k)));
        end
    end

    // Sequencer and dimmer state update
    always_comb begin
        n_state      = r_state;
        n_after_fire = r_after_fire;
        n_sched_fire = r_sched_fire;
        n_wait       = '0;
        n_since      = r_since;
        n_fref       = r_fref;
        n_countdown  = r_countdown;
        n_armed      = r_armed;
        n_healthy    = r_healthy;
        n_shutoff    = r_shutoff;
        n_pulse_left = r_pulse_left;
        n_gate       = r_gate;
        n_out_valid  = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_cmd == CMD_TICK) begin
                        n_state = S_TICK;
                    end else if (i_cmd == CMD_SET_ONE || i_cmd == CMD_SET_ALL) begin
                        n_state = S_LV_MUL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_TICK: begin
                // advance time, run out the pulse, step the countdown
                if (r_since != TIME_MAX) begin
                    n_since = r_since + 1'b1;
                end
                if (r_pulse_left != 8'd0) begin
                    n_pulse_left = r_pulse_left - 8'd1;
                    if (r_pulse_left == 8'd1) begin
                        n_gate = '0;
                    end
                end
                if (r_armed) begin
                    n_countdown = cd_step;
                end
                if (r_armed && cd_step == 16'd0) begin
                    n_after_fire = 1'b1;
                    n_state      = S_SRCH;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_SRCH: begin
                // wait for the minimum to travel the whole chain
                if (r_wait == SCAN_CW'(CHANNELS - 1)) begin
                    n_state = r_after_fire ? S_FIRE : S_SCHED;
                end else begin
                    n_wait = r_wait + 1'b1;
                end
            end
            S_FIRE: begin
                if (!i_scan_end.found) begin
                    n_armed = 1'b0;
                    n_state = S_EDGE;
                end else begin
                    if (r_pulse != 8'd0) begin
                        n_gate       = r_gate | i_grp;
                        n_pulse_left = r_pulse;
                    end
                    n_fref       = i_scan_end.best;
                    n_after_fire = 1'b0;
                    n_sched_fire = 1'b1;
                    n_state      = S_SRCH;
                end
            end
            S_SCHED: begin
                if (!i_scan_end.found) begin
                    n_armed = 1'b0;
                end else begin
                    n_countdown = gap;
                    n_armed     = 1'b1;
                end
                n_state = r_sched_fire ? S_EDGE : S_WDOG;
            end
            S_EDGE: begin
                if (zc_take) begin
                    n_since   = '0;
                    n_healthy = 1'b1;
                    n_fref    = 16'd0;
                    if (!r_shutoff) begin
                        n_after_fire = 1'b0;
                        n_sched_fire = 1'b0;
                        n_state      = S_SRCH;
                    end else begin
                        n_state = S_WDOG;
                    end
                end else begin
                    n_state = S_WDOG;
                end
            end
            S_WDOG: begin
                // drop everything on zero-cross loss, recover when it returns
                if (r_since > TIME_BITS'(r_lost)) begin
                    if (r_healthy) begin
                        n_healthy    = 1'b0;
                        n_shutoff    = 1'b1;
                        n_armed      = 1'b0;
                        n_pulse_left = 8'd0;
                        n_gate       = '0;
                    end
                end else begin
                    n_healthy = 1'b1;
                    n_shutoff = 1'b0;
                end
                n_state = S_DONE;
            end
            S_LV_MUL: n_state = S_LV_DIV;
            S_LV_DIV: n_state = S_LV_WR;
            S_LV_WR:  n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after_fire <= 1'b0;
            r_sched_fire <= 1'b0;
            r_wait       <= '0;
            r_since      <= '0;
            r_fref       <= 16'd0;
            r_countdown  <= 16'd0;
            r_armed      <= 1'b0;
            r_healthy    <= 1'b0;
            r_shutoff    <= 1'b0;
            r_pulse_left <= 8'd0;
            r_gate       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_after_fire <= n_after_fire;
            r_sched_fire <= n_sched_fire;
            r_wait       <= n_wait;
            r_since      <= n_since;
            r_fref       <= n_fref;
            r_countdown  <= n_countdown;
            r_armed      <= n_armed;
            r_healthy    <= n_healthy;
            r_shutoff    <= n_shutoff;
            r_pulse_left <= n_pulse_left;
            r_gate       <= n_gate;
            r_out_valid  <= n_out_valid;
        end
    end

    // Load the result item
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_gates   <= (r_pulse_left != 8'd0) ? GATES_W'(r_gate) : '0;
            r_o_healthy <= r_healthy;
            r_o_emerg   <= r_shutoff;
            r_o_armed   <= r_armed;
            r_o_fref    <= r_fref;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_gates           = r_o_gates;
    assign o_zc_healthy      = r_o_healthy;
    assign o_emergency       = r_o_emerg;
    assign o_timer_armed     = r_o_armed;
    assign o_last_fire_delay = r_o_fref;

`ifndef SYNTHESIS
    a_shutoff_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shutoff |-> !r_armed)
        else $error("countdown armed during emergency shutoff");

    a_gate_needs_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pulse_left == 8'd0) |-> (r_gate == '0))
        else $error("gate mask left set with no pulse running");

    a_armed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_armed) |-> (r_countdown != 16'd0))
        else $error("armed countdown at zero between items");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start processing");
`endif

endmodule

// ===== rtl/core/multichannel_phase_angle_dimmer.sv =====
`timescale 1ns / 1ps
// A set command runs the level map through its multiply, divide and write states.
// A tick that fires and takes a zero-cross edge needs three chain searches;
// each search is one pass of the minimum down the cells. One item at a time:
// the next item is accepted once the result is loaded into the output register.
// Reset: synchronous, clears all control state, sets every channel off and every
// configuration register to its default; no clearing pass.
// ----------------------------------------------------------------------------
// multichannel_phase_angle_dimmer
// Phase-angle triac dimmer for several channels, driven by microsecond ticks,
// built as a sequencer over a chain of channel cells.
// ----------------------------------------------------------------------------
module multichannel_phase_angle_dimmer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mpad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mpad_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_cmd,
    input  logic [2:0]                      i_channel,
    input  logic [3:0]                      i_brightness,
    input  logic                            i_zc_edge,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mpad_pkg::GATES_W-1:0]    o_gates,
    output logic                            o_zc_healthy,
    output logic                            o_emergency,
    output logic                            o_timer_armed,
    output logic [15:0]                     o_last_fire_delay
);
    import mpad_pkg::*;

    t_cell_ctl           ctl;
    logic [CHANNELS-1:0] wr;
    logic [CHANNELS-1:0] grp;
    t_scan               link [CHANNELS+1];

    // Sequencer
    mpad_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_channel         (i_channel),
        .i_brightness      (i_brightness),
        .i_zc_edge         (i_zc_edge),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_gates           (o_gates),
        .o_zc_healthy      (o_zc_healthy),
        .o_emergency       (o_emergency),
        .o_timer_armed     (o_timer_armed),
        .o_last_fire_delay (o_last_fire_delay),
        .o_ctl             (ctl),
        .o_wr              (wr),
        .o_seed            (link[0]),
        .i_scan_end        (link[CHANNELS]),
        .i_grp             (grp)
    );

    // Chain of channel cells
    for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
        mpad_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_wr    (wr[k]),
            .i_scan  (link[k]),
            .o_scan  (link[k+1]),
            .o_grp   (grp[k])
        );
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel phase-angle dimmer. A driver
// streams ticks and brightness commands from a queue. On every accepted item
// a cycle-free predictor of the dimmer works out the expected outputs. A
// monitor compares each returned item field by field against them. Phases
// rewrite all five registers while the block is idle. Both sides idle at
// random, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
    import mpad_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int          SETTLE       = 3 * CHANNELS + 16;
    localparam int          SQUEEZE_LEN  = 300;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] channel;
        logic [3:0] level;
        logic       zc;
    } t_dim_item;

    typedef struct packed {
        logic [GATES_W-1:0] gates;
        logic               healthy;
        logic               emergency;
        logic               armed;
        logic [15:0]        fire_delay;
    } t_dim_out;

    // DUT connections, with every input at a known value from time zero
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_cmd        = CMD_TICK;
    logic [2:0]           i_channel    = '0;
    logic [3:0]           i_brightness = '0;
    logic                 i_zc_edge    = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [GATES_W-1:0]   o_gates;
    logic                 o_zc_healthy;
    logic                 o_emergency;
    logic                 o_timer_armed;
    logic [15:0]          o_last_fire_delay;

    multichannel_phase_angle_dimmer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_channel        (i_channel),
        .i_brightness     (i_brightness),
        .i_zc_edge        (i_zc_edge),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_gates          (o_gates),
        .o_zc_healthy     (o_zc_healthy),
        .o_emergency      (o_emergency),
        .o_timer_armed    (o_timer_armed),
        .o_last_fire_delay(o_last_fire_delay)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Bench bookkeeping
    t_dim_item items_to_send[$];
    t_dim_out  outputs_due[$];
    t_dim_item cur_item;
    int        send_wait      = 0;
    int        send_gap_max   = 9;
    int        stall_wait     = 0;
    int        stall_max      = 9;
    int        hold_cycles    = 0;
    int        mismatch_count = 0;

    // Register copies
    logic [14:0] half_us;
    logic [13:0] min_us;
    logic [15:0] debounce_len;
    logic [19:0] lost_us;
    logic [7:0]  pulse_len;

    // Dimmer state copies
    logic [TIME_BITS-1:0] zc_age;
    logic [15:0]          chan_delay [CHANNELS];
    logic [CHANNELS-1:0]  fired_mask;
    logic [15:0]          group_ref;
    logic [15:0]          fire_count;
    logic                 is_armed;
    logic                 is_healthy;
    logic                 is_shutoff;
    logic [7:0]           pulse_cnt;
    logic [CHANNELS-1:0]  drive_mask;

    // Brightness to firing delay; levels 1..8 interpolate toward FAR_DELAY
    function automatic logic [15:0] level_to_delay(input logic [3:0] req);
        int unsigned lvl;
        longint      span;
        lvl = (req > TOP_LEVEL) ? TOP_LEVEL : 32'(req);
        if (lvl == 0)
            return 16'(half_us + OFF_EXTRA);
        if (lvl == TOP_LEVEL)
            return 16'(min_us);
        span = longint'(TOP_LEVEL - lvl) * (longint'(FAR_DELAY) - longint'(min_us)) / 9
               + longint'(min_us);
        return 16'(span);
    endfunction

    // Smallest delay among unfired channels that lie inside the half cycle
    function automatic logic find_nearest(output int unsigned best);
        logic hit;
        int   i;
        hit  = 1'b0;
        best = 32'(half_us) + NONE_EXTRA;
        for (i = 0; i < CHANNELS; i++) begin
            if (!fired_mask[i] && chan_delay[i] < half_us && chan_delay[i] < best) begin
                best = 32'(chan_delay[i]);
                hit  = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void schedule_next();
        int unsigned target;
        int unsigned gap;
        if (!find_nearest(target)) begin
            is_armed = 1'b0;
            return;
        end
        gap = (target > group_ref) ? target - 32'(group_ref) : 1;
        if (gap < MIN_GAP)
            gap = MIN_GAP;
        fire_count = 16'(gap);
        is_armed   = 1'b1;
    endfunction

    // Fire every unfired channel within tolerance of the nearest delay
    function automatic void fire_group();
        int unsigned         target;
        logic [CHANNELS-1:0] grp;
        int                  i;
        grp = '0;
        if (!find_nearest(target)) begin
            is_armed = 1'b0;
            return;
        end
        for (i = 0; i < CHANNELS; i++) begin
            if (!fired_mask[i] && chan_delay[i] < half_us && chan_delay[i] <= target + GROUP_TOL)
                grp[i] = 1'b1;
        end
        fired_mask |= grp;
        if (pulse_len != 0) begin
            drive_mask |= grp;
            pulse_cnt   = pulse_len;
        end
        group_ref = 16'(target);
        schedule_next();
    endfunction

    function automatic void advance_tick(input logic zc_seen);
        if (zc_age != {TIME_BITS{1'b1}})
            zc_age++;
        if (pulse_cnt > 0) begin
            pulse_cnt--;
            if (pulse_cnt == 0)
                drive_mask = '0;
        end
        if (is_armed) begin
            if (fire_count > 0)
                fire_count--;
            if (fire_count == 0)
                fire_group();
        end
        if (zc_seen && zc_age >= debounce_len) begin
            zc_age     = '0;
            is_healthy = 1'b1;
            fired_mask = '0;
            group_ref  = '0;
            if (!is_shutoff)
                schedule_next();
        end
        // Watchdog on zero-cross loss
        if (zc_age > lost_us) begin
            if (is_healthy) begin
                is_healthy = 1'b0;
                is_shutoff = 1'b1;
                is_armed   = 1'b0;
                pulse_cnt  = '0;
                drive_mask = '0;
            end
        end else begin
            is_healthy = 1'b1;
            is_shutoff = 1'b0;
        end
    endfunction

    // Apply one accepted item and queue the outputs it should produce
    function automatic void predict_dimmer(input t_dim_item it);
        t_dim_out res;
        int       i;
        case (it.cmd)
            CMD_TICK: advance_tick(it.zc);
            CMD_SET_ONE: begin
                if (it.channel < CHANNELS)
                    chan_delay[it.channel] = level_to_delay(it.level);
            end
            CMD_SET_ALL: begin
                for (i = 0; i < CHANNELS; i++)
                    chan_delay[i] = level_to_delay(it.level);
            end
            default: ;
        endcase
        res.gates      = (pulse_cnt > 0) ? drive_mask : '0;
        res.healthy    = is_healthy;
        res.emergency  = is_shutoff;
        res.armed      = is_armed;
        res.fire_delay = group_ref;
        outputs_due.push_back(res);
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_HALF:  half_us      = data[14:0];
            CFG_MIN:   min_us       = data[13:0];
            CFG_DEB:   debounce_len = data[15:0];
            CFG_LOST:  lost_us      = data[19:0];
            CFG_PULSE: pulse_len    = data[7:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // Driver: hold a stalled item, otherwise advance to the next one after its gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_dimmer(cur_item);
            if (!i_in_valid || !o_in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    cur_item = items_to_send.pop_front();
                    i_cmd        <= cur_item.cmd;
                    i_channel    <= cur_item.channel;
                    i_brightness <= cur_item.level;
                    i_zc_edge    <= cur_item.zc;
                    i_in_valid   <= 1'b1;
                    send_wait = $urandom_range(0, send_gap_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted item, then stall for a random while
    always @(posedge i_clk) begin
        t_dim_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (outputs_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected item, gates %0h", $time, o_gates);
                end else begin
                    want = outputs_due.pop_front();
                    check_field("gates", 32'(want.gates), 32'(o_gates));
                    check_field("zc_healthy", 32'(want.healthy), 32'(o_zc_healthy));
                    check_field("emergency", 32'(want.emergency), 32'(o_emergency));
                    check_field("timer_armed", 32'(want.armed), 32'(o_timer_armed));
                    check_field("last_fire_delay", 32'(want.fire_delay),
                                32'(o_last_fire_delay));
                end
                stall_wait = $urandom_range(0, stall_max);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else if (stall_wait > 0) begin
                stall_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic [1:0] cmd, input logic [2:0] ch,
                             input logic [3:0] lvl, input logic zc);
        t_dim_item it;
        it.cmd     = cmd;
        it.channel = ch;
        it.level   = lvl;
        it.zc      = zc;
        items_to_send.push_back(it);
    endtask

    // Mostly ticks with edges at a jittered period, some set commands and noise
    task automatic fill_phase(input int n, input int per_lo, input int per_hi);
        int         k;
        int         roll;
        int         since_edge;
        int         next_edge;
        logic [1:0] cmd;
        logic [3:0] lvl;
        logic       zc;
        since_edge = 0;
        next_edge  = $urandom_range(per_lo, per_hi);
        // Prime a few channels so groups fire early in the phase
        push_item(CMD_SET_ONE, 3'($urandom_range(0, 7)), 4'd9, 1'b0);
        push_item(CMD_SET_ONE, 3'($urandom_range(0, 7)), 4'd8, 1'b1);
        push_item(CMD_SET_ONE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 1'b0);
        for (k = 3; k < n; k++) begin
            roll = $urandom_range(0, 99);
            lvl  = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(7, 15))
                                                : 4'($urandom_range(0, 15));
            zc   = 1'($urandom_range(0, 1));
            if (roll < 5) begin
                cmd = CMD_SET_ONE;
            end else if (roll < 7) begin
                cmd = CMD_SET_ALL;
            end else if (roll < 8) begin
                cmd = CMD_UNUSED;
            end else begin
                cmd = CMD_TICK;
                since_edge++;
                if (since_edge >= next_edge) begin
                    zc         = 1'b1;
                    since_edge = 0;
                    next_edge  = $urandom_range(per_lo, per_hi);
                end else begin
                    zc = ($urandom_range(0, 99) < 3);
                end
            end
            push_item(cmd, 3'($urandom_range(0, 7)), lvl, zc);
        end
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || i_in_valid || outputs_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DAT_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, CFG_DAT_W'(val));
    endtask

    task automatic run_phase(input int unsigned half, input int unsigned min_d,
                             input int unsigned deb, input int unsigned lost,
                             input int unsigned pls, input int n, input int per_lo,
                             input int per_hi, input int gap_max, input int stall_lim,
                             input bit squeeze);
        wait_drained();
        cfg_write(CFG_HALF, half);
        cfg_write(CFG_MIN, min_d);
        cfg_write(CFG_DEB, deb);
        cfg_write(CFG_LOST, lost);
        cfg_write(CFG_PULSE, pls);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        send_gap_max = gap_max;
        stall_max    = stall_lim;
        if (squeeze)
            hold_cycles = SQUEEZE_LEN;
        fill_phase(n, per_lo, per_hi);
    endtask

    initial begin
        int i;
        // Power-on state of the predictor
        half_us      = 15'(HALF_RST);
        min_us       = 14'(MIN_RST);
        debounce_len = 16'(DEB_RST);
        lost_us      = 20'(LOST_RST);
        pulse_len    = 8'(PULSE_RST);
        zc_age       = '0;
        for (i = 0; i < CHANNELS; i++)
            chan_delay[i] = 16'(DELAY_RST);
        fired_mask = '0;
        group_ref  = '0;
        fire_count = '0;
        is_armed   = 1'b0;
        is_healthy = 1'b0;
        is_shutoff = 1'b0;
        pulse_cnt  = '0;
        drive_mask = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: unused command, clamping, off level, every channel, ignored fields
        push_item(CMD_UNUSED, 3'd7, 4'd15, 1'b1);
        push_item(CMD_SET_ALL, 3'd0, 4'd0, 1'b0);
        push_item(CMD_SET_ALL, 3'd5, 4'd15, 1'b1);
        push_item(CMD_SET_ONE, 3'd0, 4'd9, 1'b0);
        push_item(CMD_SET_ONE, 3'd1, 4'd8, 1'b0);
        push_item(CMD_SET_ONE, 3'd2, 4'd1, 1'b0);
        push_item(CMD_SET_ONE, 3'd3, 4'd0, 1'b0);
        push_item(CMD_SET_ONE, 3'd4, 4'd15, 1'b1);
        push_item(CMD_SET_ONE, 3'd5, 4'd5, 1'b0);
        push_item(CMD_SET_ONE, 3'd6, 4'd10, 1'b0);
        push_item(CMD_SET_ONE, 3'd7, 4'd4, 1'b0);
        push_item(CMD_TICK, 3'd0, 4'd0, 1'b1);
        push_item(CMD_TICK, 3'd0, 4'd0, 1'b0);
        push_item(CMD_TICK, 3'd7, 4'd15, 1'b1);
        push_item(CMD_SET_ONE, 3'd0, 4'd0, 1'b1);

        // Low extremes, no idling on either side
        run_phase(1000, 10, 0, 1000, 1, 240, 40, 150, 0, 0, 1'b0);
        // High extremes, full width of every register
        run_phase(32767, 16383, 65535, 1048575, 255, 120, 100, 300, 9, 9, 1'b0);
        // Tiny minimum delay, long pulses, output held off to back up the input
        run_phase($urandom_range(300, 1500), $urandom_range(0, 9), $urandom_range(0, 40),
                  $urandom_range(200, 400), $urandom_range(20, 120), 260, 50, 250, 9, 0,
                  1'b1);
        // Zero pulse length, edge gaps that can outlast the watchdog
        run_phase($urandom_range(100, 600), $urandom_range(20, 120), $urandom_range(0, 30),
                  $urandom_range(150, 300), 0, 240, 60, 400, 0, 9, 1'b0);
        // Overlapping pulses on channels left at earlier minimum delays
        run_phase($urandom_range(500, 2000), $urandom_range(30, 200), $urandom_range(0, 60),
                  $urandom_range(300, 600), $urandom_range(100, 255), 260, 80, 300,
                  $urandom_range(0, 9), $urandom_range(0, 9), 1'b0);
        // Zero half cycle: nothing may fire
        run_phase(0, 0, 0, $urandom_range(100, 200), $urandom_range(1, 10), 200, 20, 300,
                  9, 9, 1'b0);
        // Minimum delay above the far delay: the level map runs upward
        run_phase($urandom_range(20000, 32767), $urandom_range(9000, 16383),
                  $urandom_range(0, 100), $urandom_range(1000, 5000), 10, 200, 50, 400,
                  5, 5, 1'b0);
        run_phase($urandom_range(200, 1200), $urandom_range(0, 150), $urandom_range(0, 100),
                  $urandom_range(200, 800), $urandom_range(1, 60), 420, 30, 500, 4, 4,
                  1'b0);

        wait_drained();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Run limit
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mpad_pkg.sv
rtl/core/mpad_cell.sv
rtl/core/mpad_ctrl.sv
rtl/core/multichannel_phase_angle_dimmer.sv
tb/tb_top.sv
